FILE: hw/rtl/krsm_pkg.sv
// Shared types and constants for the keyboard report slot manager.
// Used by krsm_ctrl, krsm_dpath and keyboard_report_slot_manager; no dependencies.
`timescale 1ns / 1ps

package krsm_pkg;

  // The report holds eight bytes: a modifier byte, a reserved byte and six key slots.
  localparam int REPORT_BYTES_DEF = 8;
  // Number of key slots on the result ports.
  localparam int OUT_SLOTS = 6;

  localparam int KEY_W  = 8;
  localparam int CODE_W = 16;
  localparam int FUNC_W = 3;

  // A keycode whose high byte is this tag carries a modifier bit mask in its low byte.
  localparam logic [CODE_W-1:0] MOD_TAG   = 16'hE000;
  localparam logic [CODE_W-1:0] HIGH_MASK = 16'hFF00;
  localparam logic [CODE_W-1:0] LOW_MASK  = 16'h00FF;

  // Operation codes of the func field.
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_PRESS   = 3'd0;
  localparam func_t FUNC_HOLD    = 3'd1;
  localparam func_t FUNC_RELEASE = 3'd2;
  localparam func_t FUNC_TOGGLE  = 3'd3;
  localparam func_t FUNC_CLEAR   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the transaction and the slot compare results
    logic update;   // apply the operation and load the result register
  } krsm_cmd_t;

endpackage

FILE: hw/rtl/krsm_ctrl.sv
// Controller for the keyboard report slot manager: sequences capture and update.
// Depends on krsm_pkg for the command struct.
`timescale 1ns / 1ps

module krsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output krsm_pkg::krsm_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register can take a new report when it is empty or is read now.
  assign out_free = !out_valid || !out_stall;

  assign in_stall    = (state != ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && in_valid;
  assign cmd.update  = (state == ST_UPDATE) && out_free;

  // Next state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag: set on update, cleared when the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // An accepted input transaction is always followed by the update state.
  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_UPDATE && in_stall))
    else $error("accepted transaction did not enter the update state");

  // Every update produces a pending result on the next cycle.
  a_update_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> out_valid)
    else $error("update did not raise the result valid");

  // Capture and update never happen in the same cycle.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.update))
    else $error("capture and update issued together");

endmodule

FILE: hw/rtl/krsm_dpath.sv
// Datapath for the keyboard report slot manager: key slots, modifier byte,
// compare and compaction logic, and the result register. Depends on krsm_pkg.
`timescale 1ns / 1ps

module krsm_dpath #(
  parameter int NUM_SLOTS = krsm_pkg::REPORT_BYTES_DEF - 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  krsm_pkg::krsm_cmd_t             cmd,
  input  logic [krsm_pkg::FUNC_W-1:0]     func,
  input  logic [krsm_pkg::CODE_W-1:0]     keycode,
  output logic [krsm_pkg::KEY_W-1:0]      modifier_bits,
  output logic [krsm_pkg::KEY_W-1:0]      out_slot [krsm_pkg::OUT_SLOTS]
);

  localparam int KW = krsm_pkg::KEY_W;

  // Held report state.
  logic [KW-1:0]        mods;
  logic [KW-1:0]        slots      [NUM_SLOTS];
  logic [KW-1:0]        mods_next;
  logic [KW-1:0]        slots_next [NUM_SLOTS];

  // Captured transaction and compare results.
  krsm_pkg::func_t      op;
  logic [KW-1:0]        key;
  logic                 is_mod;
  logic                 present;
  logic [NUM_SLOTS-1:0] hit_eq;
  logic [NUM_SLOTS-1:0] hit_zero;

  // Compare results for the incoming transaction against the current state.
  logic [KW-1:0]        in_key;
  logic                 in_is_mod;
  logic [NUM_SLOTS-1:0] in_eq;
  logic [NUM_SLOTS-1:0] in_zero;

  // Update decode.
  logic                 do_add;
  logic                 do_rem;
  logic                 do_clr;
  logic [NUM_SLOTS-1:0] add_hit;
  logic [NUM_SLOTS-1:0] add_pos;
  logic [NUM_SLOTS-1:0] rem_pos;
  logic [NUM_SLOTS-1:0] rem_ge;

  // Compare the incoming key with every slot.
  assign in_key    = KW'(keycode & krsm_pkg::LOW_MASK);
  assign in_is_mod = ((keycode & krsm_pkg::HIGH_MASK) == krsm_pkg::MOD_TAG);

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      in_eq[i]   = (slots[i] == in_key);
      in_zero[i] = (slots[i] == '0);
    end
  end

  // Capture register for the transaction and its compare results.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= func;
      key      <= in_key;
      is_mod   <= in_is_mod;
      hit_eq   <= in_eq;
      hit_zero <= in_zero;
      present  <= in_is_mod ? ((mods & in_key) != '0) : (|in_eq);
    end
  end

  // Decode the operation into add, remove or clear.
  always_comb begin
    do_add = 1'b0;
    do_rem = 1'b0;
    do_clr = 1'b0;
    case (op) inside
      krsm_pkg::FUNC_PRESS, krsm_pkg::FUNC_HOLD: do_add = 1'b1;
      krsm_pkg::FUNC_RELEASE:                     do_rem = 1'b1;
      krsm_pkg::FUNC_TOGGLE: begin
        do_add = !present;
        do_rem = present;
      end
      krsm_pkg::FUNC_CLEAR:                       do_clr = 1'b1;
      default: ;
    endcase
  end

  // Add goes to the first slot that is free or already holds the key;
  // remove starts at the first slot holding the key.
  assign add_hit = hit_eq | hit_zero;
  assign add_pos = add_hit & (~add_hit + NUM_SLOTS'(1));
  assign rem_pos = hit_eq & (~hit_eq + NUM_SLOTS'(1));
  assign rem_ge  = ~(rem_pos - NUM_SLOTS'(1));

  // Next state of the modifier byte and the slots.
  always_comb begin
    mods_next = mods;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      slots_next[j] = slots[j];
    end
    if (do_clr) begin
      mods_next = '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        slots_next[j] = '0;
      end
    end else if (is_mod) begin
      if (do_add) begin
        mods_next = mods | key;
      end else if (do_rem) begin
        mods_next = mods & ~key;
      end
    end else if (do_add) begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (add_pos[j]) begin
          slots_next[j] = key;
        end
      end
    end else if (do_rem) begin
      // Slots from the removed one onward move forward; the last becomes empty.
      for (int j = 0; j < NUM_SLOTS - 1; j++) begin
        if (rem_ge[j]) begin
          slots_next[j] = slots[j+1];
        end
      end
      if (rem_ge[NUM_SLOTS-1]) begin
        slots_next[NUM_SLOTS-1] = '0;
      end
    end
  end

  // Report state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mods <= '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        slots[j] <= '0;
      end
    end else if (cmd.update) begin
      mods <= mods_next;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        slots[j] <= slots_next[j];
      end
    end
  end

  // Result register: the updated report, with slots beyond the held count read as zero.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      modifier_bits <= mods_next;
    end
  end

  for (genvar g = 0; g < krsm_pkg::OUT_SLOTS; g++) begin : g_out
    if (g < NUM_SLOTS) begin : g_held
      always_ff @(posedge clk) begin
        if (cmd.update) begin
          out_slot[g] <= slots_next[g];
        end
      end
    end else begin : g_empty
      always_ff @(posedge clk) begin
        if (cmd.update) begin
          out_slot[g] <= '0;
        end
      end
    end
  end

  // At most one slot is chosen for an add.
  a_add_onehot: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $onehot0(add_pos))
    else $error("add selected more than one slot");

  // Clear all leaves an empty modifier byte and first slot.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && op == krsm_pkg::FUNC_CLEAR) |=> (mods == '0 && slots[0] == '0))
    else $error("clear all left held keys");

endmodule

FILE: hw/rtl/keyboard_report_slot_manager.sv
// Top level of the keyboard report slot manager: joins controller and datapath.
// Depends on krsm_pkg, krsm_ctrl and krsm_dpath.
// Sequence: an accepted input transaction is captured in the idle state, then the update
// state applies it and loads the result register, which raises out_valid; the update
// waits while the result register is full, and no new transaction is taken until it is done.
// Reset: rst clears the modifier byte, all key slots and the result valid flag.
`timescale 1ns / 1ps

module keyboard_report_slot_manager #(
  parameter int REPORT_BYTES = krsm_pkg::REPORT_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [krsm_pkg::FUNC_W-1:0] func,
  input  logic [krsm_pkg::CODE_W-1:0] keycode,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [krsm_pkg::KEY_W-1:0]  modifier_bits,
  output logic [krsm_pkg::KEY_W-1:0]  slot_zero,
  output logic [krsm_pkg::KEY_W-1:0]  slot_one,
  output logic [krsm_pkg::KEY_W-1:0]  slot_two,
  output logic [krsm_pkg::KEY_W-1:0]  slot_three,
  output logic [krsm_pkg::KEY_W-1:0]  slot_four,
  output logic [krsm_pkg::KEY_W-1:0]  slot_five
);

  localparam int NumSlots = REPORT_BYTES - 2;

  krsm_pkg::krsm_cmd_t          cmd;
  logic [krsm_pkg::KEY_W-1:0]   out_slot [krsm_pkg::OUT_SLOTS];

  // Sequencing of capture and update.
  krsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Report state and update logic.
  krsm_dpath #(
    .NUM_SLOTS (NumSlots)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (func),
    .keycode       (keycode),
    .modifier_bits (modifier_bits),
    .out_slot      (out_slot)
  );

  assign slot_zero  = out_slot[0];
  assign slot_one   = out_slot[1];
  assign slot_two   = out_slot[2];
  assign slot_three = out_slot[3];
  assign slot_four  = out_slot[4];
  assign slot_five  = out_slot[5];

endmodule
